/* src/link_frame_deframer_assert.svh */
// Assertion macros used by the link frame deframer checker
`ifndef LINK_FRAME_DEFRAMER_ASSERT_SVH
`define LINK_FRAME_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define LFD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("link_frame_deframer: same-cycle check failed");

// next-cycle implication
`define LFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("link_frame_deframer: next-cycle check failed");

`endif

/* src/lfd_pkg.sv */
// Types and constants of the link frame deframer
package lfd_pkg;

    localparam int LFD_BLOB_SLOTS = 16;
    localparam logic [31:0] LFD_MAX_LEN_RST   = 32'd16777216;
    localparam logic [4:0]  LFD_MAX_BLOBS_RST = 5'd16;

    localparam logic [0:0] CFG_MAX_LEN   = 1'b0;
    localparam logic [0:0] CFG_MAX_BLOBS = 1'b1;

    localparam logic [2:0] PH_MSG_LEN   = 3'd0;
    localparam logic [2:0] PH_MSG_BODY  = 3'd1;
    localparam logic [2:0] PH_COUNT     = 3'd2;
    localparam logic [2:0] PH_BLOB_LEN  = 3'd3;
    localparam logic [2:0] PH_BLOB_BODY = 3'd4;
    localparam logic [2:0] PH_ERROR     = 3'd5;

    localparam logic [1:0] KIND_FIELD = 2'd0;
    localparam logic [1:0] KIND_MSG   = 2'd1;
    localparam logic [1:0] KIND_BLOB  = 2'd2;
    localparam logic [1:0] KIND_DROP  = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [3:0] blob_number;
        logic       blob_end;
        logic       frame_end;
        logic       malformed;
    } t_tag;

endpackage

/* src/lfd_byte_if.sv */
// Byte stream channel
interface lfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

/* src/lfd_tag_if.sv */
// Tagged byte result channel
interface lfd_tag_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [3:0] blob_number;
    logic       blob_end;
    logic       frame_end;
    logic       malformed;

    modport source (output valid, output out_byte, output kind, output blob_number,
                    output blob_end, output frame_end, output malformed, input ready);
    modport sink (input valid, input out_byte, input kind, input blob_number,
                  input blob_end, input frame_end, input malformed, output ready);
endinterface

/* src/lfd_parser.sv */
// Frame parser state and per-byte tagging logic
module lfd_parser
    import lfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic [31:0] i_max_len,
    input  logic [4:0]  i_max_blobs,
    output t_tag        o_tag
);

    localparam logic [6:0] SLOTS = 7'(LFD_BLOB_SLOTS);

    logic [2:0]  r_phase,      n_phase;
    logic [1:0]  r_pos,        n_pos;
    logic [31:0] r_shift,      n_shift;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [4:0]  r_blobs_left, n_blobs_left;
    logic [3:0]  r_blob_index, n_blob_index;

    logic [31:0] fld;
    logic [6:0]  limit;
    logic        close;

    always_comb begin
        n_phase      = r_phase;
        n_pos        = r_pos;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_blobs_left = r_blobs_left;
        n_blob_index = r_blob_index;
        close        = 1'b0;
        o_tag        = '0;
        o_tag.out_byte = i_byte;
        o_tag.kind     = KIND_FIELD;
        fld   = r_shift | (32'(i_byte) << {r_pos, 3'b000});
        limit = ({2'b00, i_max_blobs} > SLOTS) ? SLOTS : {2'b00, i_max_blobs};

        unique case (r_phase)
            PH_ERROR: begin
                o_tag.kind = KIND_DROP;
            end
            PH_MSG_BODY: begin
                o_tag.kind   = KIND_MSG;
                n_bytes_left = r_bytes_left - 32'd1;
                if (r_bytes_left == 32'd1) begin
                    n_phase = PH_COUNT;
                end
            end
            PH_BLOB_BODY: begin
                o_tag.kind        = KIND_BLOB;
                o_tag.blob_number = r_blob_index;
                n_bytes_left      = r_bytes_left - 32'd1;
                close             = (r_bytes_left == 32'd1);
            end
            PH_MSG_LEN, PH_COUNT, PH_BLOB_LEN: begin
                if (r_phase == PH_BLOB_LEN) begin
                    o_tag.blob_number = r_blob_index;
                end
                if (r_pos != 2'd3) begin
                    n_pos   = r_pos + 2'd1;
                    n_shift = fld;
                end else begin
                    n_pos   = 2'd0;
                    n_shift = '0;
                    if (r_phase == PH_COUNT) begin
                        if (fld > 32'(limit)) begin
                            o_tag.malformed = 1'b1;
                            n_phase         = PH_ERROR;
                        end else if (fld == 32'd0) begin
                            o_tag.frame_end = 1'b1;
                            n_phase         = PH_MSG_LEN;
                        end else begin
                            n_blobs_left = fld[4:0];
                            n_blob_index = '0;
                            n_phase      = PH_BLOB_LEN;
                        end
                    end else if (fld > i_max_len) begin
                        o_tag.malformed = 1'b1;
                        n_phase         = PH_ERROR;
                    end else if (fld == 32'd0) begin
                        if (r_phase == PH_MSG_LEN) begin
                            n_phase = PH_COUNT;
                        end else begin
                            close = 1'b1;
                        end
                    end else begin
                        n_bytes_left = fld;
                        n_phase      = (r_phase == PH_MSG_LEN) ? PH_MSG_BODY : PH_BLOB_BODY;
                    end
                end
            end
            default: begin
                o_tag.kind = KIND_DROP;
            end
        endcase

        if (close) begin
            o_tag.blob_end = 1'b1;
            n_blobs_left   = r_blobs_left - 5'd1;
            if (r_blobs_left == 5'd1) begin
                o_tag.frame_end = 1'b1;
                n_blob_index    = '0;
                n_phase         = PH_MSG_LEN;
            end else begin
                n_blob_index = r_blob_index + 4'd1;
                n_phase      = PH_BLOB_LEN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_MSG_LEN;
            r_pos        <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
            r_blobs_left <= '0;
            r_blob_index <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_pos        <= n_pos;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_blobs_left <= n_blobs_left;
            r_blob_index <= n_blob_index;
        end
    end

endmodule

/* src/lfd_out_reg.sv */
// Result register towards the output channel
module lfd_out_reg
    import lfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_tag i_tag,
    input  logic i_ready,
    output logic o_can_load,
    output logic o_valid,
    output t_tag o_tag
);

    logic r_valid;
    t_tag r_tag;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_tag      = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_tag <= i_tag;
        end
    end

endmodule

/* src/link_frame_deframer.sv */
// Link frame deframer: tags each byte of a length-prefixed frame stream.
//
// Input channel i_in carries one stream byte per transfer. Output channel
// o_out returns one tagged byte per input byte, in order: the byte itself,
// its kind (length/count field, message, blob, or discarded), blob number,
// blob and frame end marks, and a malformed flag on the byte that completes
// a length above max_len or a count above min(max_blobs, 16).
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 max_len, 1 max_blobs from the low 5 bits); write only while idle.
// From input transfer to result valid, a byte passes the input register,
// then the parser step into the result register.
// Throughput is one byte per cycle while o_out is not stalled.
// After a malformed field all later bytes come out as discarded until reset.
// A stalled receiver holds the result register; the input register still
// takes one more byte, then i_in.ready drops until o_out drains.
// Synchronous active-low reset clears the parser to the message length
// field, empties both registers and restores the register defaults.
module link_frame_deframer
    import lfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lfd_byte_if.sink    i_in,
    lfd_tag_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_max_len;
    logic [4:0]  r_max_blobs;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        in_xfer;
    logic        advance;
    logic        can_load;
    t_tag        step_tag;
    t_tag        out_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= LFD_MAX_LEN_RST;
            r_max_blobs <= LFD_MAX_BLOBS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_LEN:   r_max_len   <= i_cfg_data;
                CFG_MAX_BLOBS: r_max_blobs <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign advance    = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || advance;
    assign in_xfer    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_xfer || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    lfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_byte      (r_in_byte),
        .i_max_len   (r_max_len),
        .i_max_blobs (r_max_blobs),
        .o_tag       (step_tag)
    );

    lfd_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid),
        .i_tag      (step_tag),
        .i_ready    (o_out.ready),
        .o_can_load (can_load),
        .o_valid    (o_out.valid),
        .o_tag      (out_tag)
    );

    assign o_out.out_byte    = out_tag.out_byte;
    assign o_out.kind        = out_tag.kind;
    assign o_out.blob_number = out_tag.blob_number;
    assign o_out.blob_end    = out_tag.blob_end;
    assign o_out.frame_end   = out_tag.frame_end;
    assign o_out.malformed   = out_tag.malformed;

endmodule

/* src/lfd_checker.sv */
// Port-level checks of the link frame deframer and their bind
`include "link_frame_deframer_assert.svh"

module lfd_checker
    import lfd_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_kind,
    input logic [3:0] i_blob_number,
    input logic       i_blob_end,
    input logic       i_frame_end,
    input logic       i_malformed
);

    logic r_err;
    logic xfer;

    assign xfer = i_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else if (xfer && i_malformed) begin
            r_err <= 1'b1;
        end
    end

    `LFD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready,
        i_valid && $stable(i_out_byte) && $stable(i_kind) && $stable(i_malformed))
    `LFD_ASSERT_NOW(a_bad_field, i_clk, i_rst_n, i_valid && i_malformed,
        i_kind == KIND_FIELD && !i_blob_end && !i_frame_end)
    `LFD_ASSERT_NOW(a_sticky_drop, i_clk, i_rst_n, i_valid && r_err,
        i_kind == KIND_DROP && !i_malformed && !i_blob_end && !i_frame_end
        && i_blob_number == 4'd0)
    `LFD_ASSERT_NOW(a_msg_clean, i_clk, i_rst_n, i_valid && i_kind == KIND_MSG,
        !i_blob_end && !i_frame_end && i_blob_number == 4'd0 && !i_malformed)
    `LFD_ASSERT_NOW(a_blob_frame, i_clk, i_rst_n,
        i_valid && i_frame_end && i_kind == KIND_BLOB, i_blob_end)

endmodule

bind link_frame_deframer lfd_checker u_lfd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_kind        (o_out.kind),
    .i_blob_number (o_out.blob_number),
    .i_blob_end    (o_out.blob_end),
    .i_frame_end   (o_out.frame_end),
    .i_malformed   (o_out.malformed)
);
